// ----- rtl/jvcp_pkg.sv -----
`default_nettype none
package jvcp_pkg;

	// joint count and field widths
	localparam int NJ    = 7;
	localparam int PW    = 20;          // Q4.16 position
	localparam int MW    = 19;          // Q3.16 speed limit
	localparam int CIW   = 3;           // register index
	localparam int MAGW  = 24;          // |8*(target - measured)|
	localparam int SQW   = 2 * MAGW - 1; // one square, at most 2^46
	localparam int SW    = 50;          // sum of seven squares
	localparam int ROOTW = 25;          // floor(sqrt) of the sum
	localparam int PMW   = MAGW + MW;   // |v| * limit
	localparam int NLW   = PMW + 3;     // 5 * |v| * limit
	localparam int NUW   = MAGW + 3;    // 5 * |v|
	localparam int QW    = 26;          // rounded step magnitude

	localparam int POS_MAX = 524287;
	localparam int POS_MIN = -524288;

	typedef logic signed [PW-1:0] pos_t;
	typedef logic [MW-1:0]        speed_t;
	typedef logic [CIW-1:0]       cfg_idx_t;

	// register map: targets sit at their joint number
	localparam cfg_idx_t REG_TARGET0   = 3'd0;
	localparam cfg_idx_t REG_MAX_SPEED = 3'd7;

	localparam speed_t MAX_SPEED_RST = 19'd65536;

endpackage
`default_nettype wire

// ----- rtl/jvcp_if.sv -----
`default_nettype none
// measured positions in
interface jvcp_in_if import jvcp_pkg::*; ();
	logic valid;
	logic ready;
	pos_t measured_joint0;
	pos_t measured_joint1;
	pos_t measured_joint2;
	pos_t measured_joint3;
	pos_t measured_joint4;
	pos_t measured_joint5;
	pos_t measured_joint6;

	modport source (output valid, measured_joint0, measured_joint1, measured_joint2,
		measured_joint3, measured_joint4, measured_joint5, measured_joint6, input ready);
	modport sink (input valid, measured_joint0, measured_joint1, measured_joint2,
		measured_joint3, measured_joint4, measured_joint5, measured_joint6, output ready);
endinterface

// commanded positions out
interface jvcp_out_if import jvcp_pkg::*; ();
	logic valid;
	logic ready;
	pos_t command_joint0;
	pos_t command_joint1;
	pos_t command_joint2;
	pos_t command_joint3;
	pos_t command_joint4;
	pos_t command_joint5;
	pos_t command_joint6;
	logic speed_limited;

	modport source (output valid, command_joint0, command_joint1, command_joint2,
		command_joint3, command_joint4, command_joint5, command_joint6, speed_limited,
		input ready);
	modport sink (input valid, command_joint0, command_joint1, command_joint2,
		command_joint3, command_joint4, command_joint5, command_joint6, speed_limited,
		output ready);
endinterface

// register writes
interface jvcp_cfg_if import jvcp_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	pos_t     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/jvcp_isqrt.sv -----
`default_nettype none
// Pipelined integer square root, one root bit per stage, side data alongside.
module jvcp_isqrt import jvcp_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [SW-1:0]     in_s,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [ROOTW-1:0]       out_root,
	output logic [SIDE_W-1:0]      out_side
);
	localparam int RW = SW + 1;

	logic [RW-1:0]     rem_s  [ROOTW+1];
	logic [RW-1:0]     root_s [ROOTW+1];
	logic              vld_s  [ROOTW+1];
	logic [SIDE_W-1:0] side_s [ROOTW+1];

	assign rem_s[0]  = RW'(in_s);
	assign root_s[0] = '0;
	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < ROOTW; k++) begin : g_stage
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ROOTW - 1 - k));
		logic [RW-1:0] trial;
		logic          fit;

		// trial subtract of the next root bit
		always_comb begin
			trial = root_s[k] + BIT;
			fit   = rem_s[k] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= fit ? rem_s[k] - trial : rem_s[k];
				root_s[k+1] <= fit ? (root_s[k] >> 1) + BIT : root_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[ROOTW];
	assign out_root  = root_s[ROOTW][ROOTW-1:0];
	assign out_side  = side_s[ROOTW];
endmodule
`default_nettype wire

// ----- rtl/jvcp_div.sv -----
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in QW bits (x < y * 2^QW).
module jvcp_div #(
	parameter int XW     = 48,
	parameter int YW     = 40,
	parameter int QW     = 26,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [XW-1:0]     in_x,
	input  wire logic [YW-1:0]     in_y,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [QW-1:0]          out_q,
	output logic [SIDE_W-1:0]      out_side
);
	logic [YW-1:0]     r_s    [QW+1];
	logic [QW-1:0]     xl_s   [QW+1];
	logic [QW-1:0]     q_s    [QW+1];
	logic [YW-1:0]     y_s    [QW+1];
	logic              vld_s  [QW+1];
	logic [SIDE_W-1:0] side_s [QW+1];

	// upper dividend bits start as the remainder, the rest shift in
	assign r_s[0]    = YW'(in_x >> QW);
	assign xl_s[0]   = in_x[QW-1:0];
	assign q_s[0]    = '0;
	assign y_s[0]    = in_y;
	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [YW:0] t;
		logic        ge;

		always_comb begin
			t  = {r_s[k], xl_s[k][QW-1]};
			ge = t >= {1'b0, y_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1]    <= ge ? YW'(t - {1'b0, y_s[k]}) : t[YW-1:0];
				xl_s[k+1]   <= xl_s[k] << 1;
				q_s[k+1]    <= {q_s[k][QW-2:0], ge};
				y_s[k+1]    <= y_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_q     = q_s[QW];
	assign out_side  = side_s[QW];
endmodule
`default_nettype wire

// ----- rtl/joint_velocity_clamped_p_step_unit.sv -----
//  port    dir   handshake      word
//  cfg     in    valid/ready    index (0..6 targets, 7 speed limit), data
//  meas    in    valid/ready    measured_joint0..6
//  cmd     out   valid/ready    command_joint0..6, speed_limited
//
//  One word enters per cycle unless cmd stalls. The stages are five front ones,
//  25 square-root, two set-up, 26 divider and the output register.
//  The square root and the seven divider lanes set the depth.
//  arst_n clears all valid bits and loads the register reset values.
//  A stalled output freezes the whole pipeline; nothing is dropped or repeated.
//  cfg is always ready and should only be written while the pipe is empty.
`default_nettype none
module joint_velocity_clamped_p_step_unit import jvcp_pkg::*; #(
	parameter int RATE_HZ = 100
) (
	input wire logic   clk,
	input wire logic   arst_n,
	jvcp_cfg_if.sink   cfg,
	jvcp_in_if.sink    meas,
	jvcp_out_if.source cmd
);
	localparam int RATE   = (RATE_HZ < 1) ? 1 : RATE_HZ;
	localparam int RATE_W = $clog2(RATE + 1);
	localparam int DENW   = ROOTW + RATE_W;
	localparam int YW     = DENW + 1;
	localparam int XW     = ((NLW > DENW) ? NLW : DENW) + 2;
	localparam logic [RATE_W-1:0] RATE_V = RATE_W'(RATE);
	localparam logic signed [QW+1:0] SAT_HI = (QW+2)'(POS_MAX);
	localparam logic signed [QW+1:0] SAT_LO = (QW+2)'(POS_MIN);

	typedef struct packed {
		logic                      lim;
		logic [NJ-1:0]             neg;
		pos_t [NJ-1:0]             mpos;
		logic [NJ-1:0][NLW-1:0]    nl;
		logic [NJ-1:0][NUW-1:0]    nu;
	} sq_side_t;

	typedef struct packed {
		logic lim;
		logic neg;
		pos_t mpos;
	} dv_side_t;

	// configuration registers
	pos_t [NJ-1:0] tgt_q;
	speed_t        max_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= '0;
			max_q <= MAX_SPEED_RST;
		end else if (cfg.valid) begin
			if (cfg.index == REG_MAX_SPEED) begin
				max_q <= cfg.data[MW-1:0];
			end else begin
				tgt_q[cfg.index - REG_TARGET0] <= cfg.data;
			end
		end
	end

	// global advance: the output register is free or being drained
	logic en;
	logic out_vld_q;
	assign en         = !out_vld_q || cmd.ready;
	assign meas.ready = en;

	pos_t [NJ-1:0] m_in;
	assign m_in[0] = meas.measured_joint0;
	assign m_in[1] = meas.measured_joint1;
	assign m_in[2] = meas.measured_joint2;
	assign m_in[3] = meas.measured_joint3;
	assign m_in[4] = meas.measured_joint4;
	assign m_in[5] = meas.measured_joint5;
	assign m_in[6] = meas.measured_joint6;

	// s1: velocity magnitude and sign
	logic                    v_s1;
	pos_t [NJ-1:0]           m_s1;
	logic [NJ-1:0][MAGW-1:0] mag_s1;
	logic [NJ-1:0]           neg_s1;
	logic [NJ-1:0][MAGW-1:0] vel;

	always_comb begin
		for (int j = 0; j < NJ; j++) begin
			vel[j] = {({tgt_q[j][PW-1], tgt_q[j]} - {m_in[j][PW-1], m_in[j]}), 3'b000};
		end
	end

	// s2: squares and limit products
	logic                    v_s2;
	pos_t [NJ-1:0]           m_s2;
	logic [NJ-1:0][MAGW-1:0] mag_s2;
	logic [NJ-1:0]           neg_s2;
	logic [NJ-1:0][SQW-1:0]  sq_s2;
	logic [NJ-1:0][PMW-1:0]  pm_s2;
	logic [2*MW-1:0]         maxsq_s2;
	logic [2*MAGW-1:0]       sq_full [NJ];
	logic [PMW-1:0]          pm_full [NJ];
	logic [2*MW-1:0]         maxsq_full;

	always_comb begin
		for (int j = 0; j < NJ; j++) begin
			sq_full[j] = mag_s1[j] * mag_s1[j];
			pm_full[j] = mag_s1[j] * max_q;
		end
		maxsq_full = max_q * max_q;
	end

	// s3: pair sums and times five
	logic                    v_s3;
	pos_t [NJ-1:0]           m_s3;
	logic [NJ-1:0]           neg_s3;
	logic [3:0][SQW:0]       ps_s3;
	logic [NJ-1:0][NLW-1:0]  nl_s3;
	logic [NJ-1:0][NUW-1:0]  nu_s3;
	logic [2*MW-1:0]         maxsq_s3;

	// s4: full sum of squares
	logic                    v_s4;
	pos_t [NJ-1:0]           m_s4;
	logic [NJ-1:0]           neg_s4;
	logic [SW-1:0]           sum_s4;
	logic [NJ-1:0][NLW-1:0]  nl_s4;
	logic [NJ-1:0][NUW-1:0]  nu_s4;
	logic [2*MW-1:0]         maxsq_s4;

	// s5: limit decision
	logic                    v_s5;
	logic [SW-1:0]           sum_s5;
	sq_side_t                side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= meas.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NJ; j++) begin
				m_s1[j]   <= m_in[j];
				neg_s1[j] <= vel[j][MAGW-1];
				mag_s1[j] <= vel[j][MAGW-1] ? ~vel[j] + MAGW'(1) : vel[j];

				m_s2[j]   <= m_s1[j];
				neg_s2[j] <= neg_s1[j];
				mag_s2[j] <= mag_s1[j];
				sq_s2[j]  <= sq_full[j][SQW-1:0];
				pm_s2[j]  <= pm_full[j];

				m_s3[j]   <= m_s2[j];
				neg_s3[j] <= neg_s2[j];
				nl_s3[j]  <= (NLW'(pm_s2[j]) << 2) + NLW'(pm_s2[j]);
				nu_s3[j]  <= (NUW'(mag_s2[j]) << 2) + NUW'(mag_s2[j]);

				m_s4[j]   <= m_s3[j];
				neg_s4[j] <= neg_s3[j];
				nl_s4[j]  <= nl_s3[j];
				nu_s4[j]  <= nu_s3[j];
			end
			maxsq_s2 <= maxsq_full;

			ps_s3[0] <= (SQW+1)'(sq_s2[0]) + (SQW+1)'(sq_s2[1]);
			ps_s3[1] <= (SQW+1)'(sq_s2[2]) + (SQW+1)'(sq_s2[3]);
			ps_s3[2] <= (SQW+1)'(sq_s2[4]) + (SQW+1)'(sq_s2[5]);
			ps_s3[3] <= (SQW+1)'(sq_s2[6]);
			maxsq_s3 <= maxsq_s2;

			sum_s4   <= SW'(ps_s3[0]) + SW'(ps_s3[1]) + SW'(ps_s3[2]) + SW'(ps_s3[3]);
			maxsq_s4 <= maxsq_s3;

			sum_s5       <= sum_s4;
			side_s5.lim  <= sum_s4 > SW'(maxsq_s4);
			side_s5.neg  <= neg_s4;
			side_s5.mpos <= m_s4;
			side_s5.nl   <= nl_s4;
			side_s5.nu   <= nu_s4;
		end
	end

	// norm of the velocity vector
	logic             sq_vld;
	logic [ROOTW-1:0] root;
	sq_side_t         sq_side;

	jvcp_isqrt #(
		.SIDE_W ($bits(sq_side_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_s      (sum_s5),
		.in_side   (side_s5),
		.out_valid (sq_vld),
		.out_root  (root),
		.out_side  (sq_side)
	);

	// s6: pick numerator and denominator
	logic                   v_s6;
	logic                   lim_s6;
	logic [NJ-1:0]          neg_s6;
	pos_t [NJ-1:0]          m_s6;
	logic [DENW-1:0]        den_s6;
	logic [NJ-1:0][NLW-1:0] num_s6;
	logic [DENW-1:0]        den_lim;

	assign den_lim = root * RATE_V;

	// s7: rounding set-up, x = 2*num + den, y = 2*den
	logic                   v_s7;
	logic [YW-1:0]          y_s7;
	logic [NJ-1:0][XW-1:0]  x_s7;
	dv_side_t [NJ-1:0]      dside_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= sq_vld;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lim_s6 <= sq_side.lim;
			neg_s6 <= sq_side.neg;
			m_s6   <= sq_side.mpos;
			den_s6 <= sq_side.lim ? den_lim : DENW'(RATE_V);
			for (int j = 0; j < NJ; j++) begin
				num_s6[j] <= sq_side.lim ? sq_side.nl[j] : NLW'(sq_side.nu[j]);
				x_s7[j]   <= XW'({num_s6[j], 1'b0}) + XW'(den_s6);
				dside_s7[j].lim  <= lim_s6;
				dside_s7[j].neg  <= neg_s6[j];
				dside_s7[j].mpos <= m_s6[j];
			end
			y_s7 <= {den_s6, 1'b0};
		end
	end

	// seven divider lanes
	logic [NJ-1:0]         dv_vld;
	logic [NJ-1:0][QW-1:0] dv_q;
	dv_side_t [NJ-1:0]     dv_side;

	for (genvar j = 0; j < NJ; j++) begin : g_lane
		jvcp_div #(
			.XW     (XW),
			.YW     (YW),
			.QW     (QW),
			.SIDE_W ($bits(dv_side_t))
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_s7),
			.in_x      (x_s7[j]),
			.in_y      (y_s7),
			.in_side   (dside_s7[j]),
			.out_valid (dv_vld[j]),
			.out_q     (dv_q[j]),
			.out_side  (dv_side[j])
		);
	end

	// apply sign, add to position, saturate
	pos_t [NJ-1:0]           cmd_n;
	logic signed [QW:0]      step [NJ];
	logic signed [QW+1:0]    tot  [NJ];

	always_comb begin
		for (int j = 0; j < NJ; j++) begin
			step[j] = dv_side[j].neg ? -$signed({1'b0, dv_q[j]}) : $signed({1'b0, dv_q[j]});
			tot[j]  = $signed({{(QW+2-PW){dv_side[j].mpos[PW-1]}}, dv_side[j].mpos})
				+ $signed({step[j][QW], step[j]});
			if (tot[j] > SAT_HI) begin
				cmd_n[j] = SAT_HI[PW-1:0];
			end else if (tot[j] < SAT_LO) begin
				cmd_n[j] = SAT_LO[PW-1:0];
			end else begin
				cmd_n[j] = tot[j][PW-1:0];
			end
		end
	end

	// output register
	pos_t [NJ-1:0] cmd_q;
	logic          lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_q <= cmd_n;
			lim_q <= dv_side[0].lim;
		end
	end

	assign cmd.valid          = out_vld_q;
	assign cmd.command_joint0 = cmd_q[0];
	assign cmd.command_joint1 = cmd_q[1];
	assign cmd.command_joint2 = cmd_q[2];
	assign cmd.command_joint3 = cmd_q[3];
	assign cmd.command_joint4 = cmd_q[4];
	assign cmd.command_joint5 = cmd_q[5];
	assign cmd.command_joint6 = cmd_q[6];
	assign cmd.speed_limited  = lim_q;

	// lanes run in lock step
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(dv_vld) == 0 || $countones(dv_vld) == NJ)
		else $error("divider lanes out of step");

	// a limited word always has a nonzero norm
	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld && sq_side.lim |-> root != '0)
		else $error("limited word with zero norm");

	// divisor never zero on a live word
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> y_s7 != '0)
		else $error("zero divisor entering divider");

endmodule
`default_nettype wire

// ----- sim/tb_joint_velocity_clamped_p_step_unit.sv -----
`default_nettype none
module tb_joint_velocity_clamped_p_step_unit;
	import jvcp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RATE     = 100;
	localparam int LATENCY  = 59;
	localparam int N_RANDOM = 1630;

	typedef struct packed {
		pos_t [NJ-1:0] joint;
		logic          limited;
	} command_word_t;

	// predicts commanded positions and keeps them in arrival order
	class step_scoreboard;
		pos_t          target [NJ];
		longint        limit;
		command_word_t pending [$];
		int            errors;
		int            checked;
		int            limited_seen;

		function new();
			foreach (target[i]) target[i] = '0;
			limit = MAX_SPEED_RST;
			errors = 0;
			checked = 0;
			limited_seen = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, pos_t value);
			if (idx == REG_MAX_SPEED)
				limit = longint'(value[MW-1:0]);
			else
				target[idx] = value;
		endfunction

		// round to nearest, ties away from zero
		function longint round_div(longint num, longint den);
			longint mag, q;
			mag = (num < 0) ? -num : num;
			q = (2 * mag + den) / (2 * den);
			return (num < 0) ? -q : q;
		endfunction

		function longint int_sqrt(longint s);
			longint r;
			r = 0;
			for (int b = 25; b >= 0; b--)
				if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= s)
					r = r + (longint'(1) << b);
			return r;
		endfunction

		function void note_measured(pos_t m [NJ]);
			command_word_t w;
			longint vel [NJ];
			longint sum, norm, step, c;
			sum = 0;
			foreach (vel[i]) begin
				vel[i] = 8 * (longint'(target[i]) - longint'(m[i]));
				sum += vel[i] * vel[i];
			end
			w.limited = sum > limit * limit;
			norm = w.limited ? int_sqrt(sum) : 1;
			foreach (vel[i]) begin
				if (w.limited)
					step = round_div(5 * vel[i] * limit, norm * RATE);
				else
					step = round_div(5 * vel[i], RATE);
				c = longint'(m[i]) + step;
				if (c < POS_MIN) c = POS_MIN;
				if (c > POS_MAX) c = POS_MAX;
				w.joint[i] = pos_t'(c);
			end
			pending = {pending, w};
		endfunction

		function void check_command(command_word_t got);
			command_word_t exp_w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected command word %h", $realtime, got);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			checked++;
			if (exp_w.limited) limited_seen++;
			for (int i = 0; i < NJ; i++)
				if (got.joint[i] !== exp_w.joint[i]) begin
					$display("%0t: command_joint%0d expected %0d actual %0d",
						$realtime, i, exp_w.joint[i], got.joint[i]);
					errors++;
				end
			if (got.limited !== exp_w.limited) begin
				$display("%0t: speed_limited expected %b actual %b",
					$realtime, exp_w.limited, got.limited);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	jvcp_cfg_if cfg_ch();
	jvcp_in_if  meas_ch();
	jvcp_out_if cmd_ch();

	joint_velocity_clamped_p_step_unit #(.RATE_HZ(RATE)) uut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch.sink), .meas(meas_ch.sink),
		.cmd(cmd_ch.source)
	);

	step_scoreboard sb = new();
	int  hold_off = 0;       // long receiver stall request
	bit  stall_on = 1'b1;    // receiver stall pattern enabled
	int  sent = 0;

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		meas_ch.valid = 1'b0;
		meas_ch.measured_joint0 = '0;
		meas_ch.measured_joint1 = '0;
		meas_ch.measured_joint2 = '0;
		meas_ch.measured_joint3 = '0;
		meas_ch.measured_joint4 = '0;
		meas_ch.measured_joint5 = '0;
		meas_ch.measured_joint6 = '0;
		cmd_ch.ready = 1'b0;
	end

	// receiver: own stall pattern plus an occasional long hold-off
	always @(posedge clk) begin
		if (cmd_ch.valid && cmd_ch.ready)
			sb.check_command({cmd_ch.command_joint6, cmd_ch.command_joint5,
				cmd_ch.command_joint4, cmd_ch.command_joint3, cmd_ch.command_joint2,
				cmd_ch.command_joint1, cmd_ch.command_joint0, cmd_ch.speed_limited});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			cmd_ch.ready <= 1'b0;
		end else if (!arst_n)
			cmd_ch.ready <= 1'b0;
		else
			cmd_ch.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	// valid drops for one cycle after each register write
	task automatic write_reg(cfg_idx_t idx, pos_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, value);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// one measured word; valid stays high across back-to-back words
	task automatic send_measured(pos_t m [NJ], bit keep);
		meas_ch.valid <= 1'b1;
		meas_ch.measured_joint0 <= m[0];
		meas_ch.measured_joint1 <= m[1];
		meas_ch.measured_joint2 <= m[2];
		meas_ch.measured_joint3 <= m[3];
		meas_ch.measured_joint4 <= m[4];
		meas_ch.measured_joint5 <= m[5];
		meas_ch.measured_joint6 <= m[6];
		do @(posedge clk); while (!meas_ch.ready);
		sb.note_measured(m);
		sent++;
		if (!keep) begin
			meas_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic pos_t rand_pos(pos_t centre, int mode);
		case (mode)
			0: return pos_t'($urandom);
			1: return centre + pos_t'($urandom_range(0, 512)) - pos_t'(256);
			2: return centre + pos_t'($urandom_range(0, 65536)) - pos_t'(32768);
			default: return ($urandom_range(0, 1)) ? pos_t'(POS_MAX) : pos_t'(POS_MIN);
		endcase
	endfunction

	task automatic random_burst(int n);
		pos_t m [NJ];
		int   mode;
		for (int k = 0; k < n; k++) begin
			mode = $urandom_range(0, 9);
			mode = (mode < 2) ? 0 : (mode < 5) ? 1 : (mode < 9) ? 2 : 3;
			foreach (m[i]) m[i] = rand_pos(sb.target[i], mode);
			send_measured(m, k != n - 1);
		end
		repeat ($urandom_range(0, 6)) @(posedge clk);
	endtask

	task automatic random_targets(speed_t lim);
		for (int i = 0; i < NJ; i++)
			write_reg(cfg_idx_t'(i), pos_t'($urandom));
		write_reg(REG_MAX_SPEED, pos_t'(lim));
	endtask

	initial begin
		pos_t m [NJ];
		int   left;
		repeat (10) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: reset targets, extremes, zero and maximum limits
		foreach (m[i]) m[i] = '0;
		send_measured(m, 0);
		foreach (m[i]) m[i] = pos_t'(POS_MAX);
		send_measured(m, 1);
		foreach (m[i]) m[i] = pos_t'(POS_MIN);
		send_measured(m, 1);
		foreach (m[i]) m[i] = (i % 2) ? pos_t'(POS_MAX) : pos_t'(POS_MIN);
		send_measured(m, 0);
		// norm exactly at the limit: one joint off by 2^13 gives v = 2^16
		foreach (m[i]) m[i] = '0;
		m[3] = pos_t'(-8192);
		send_measured(m, 1);
		m[3] = pos_t'(-8193);
		send_measured(m, 1);
		m[3] = pos_t'(8192);
		send_measured(m, 0);
		drain();
		// zero limit: any nonzero velocity gives zero steps
		write_reg(REG_MAX_SPEED, '0);
		foreach (m[i]) m[i] = '0;
		send_measured(m, 1);
		m[0] = pos_t'(1);
		send_measured(m, 1);
		foreach (m[i]) m[i] = pos_t'($urandom);
		send_measured(m, 0);
		drain();
		// largest limit, extreme targets
		for (int i = 0; i < NJ; i++)
			write_reg(cfg_idx_t'(i), (i % 2) ? pos_t'(POS_MAX) : pos_t'(POS_MIN));
		write_reg(REG_MAX_SPEED, pos_t'(20'hFFFFF));
		foreach (m[i]) m[i] = (i % 2) ? pos_t'(POS_MIN) : pos_t'(POS_MAX);
		send_measured(m, 1);
		foreach (m[i]) m[i] = (i % 2) ? pos_t'(POS_MAX - 3) : pos_t'(POS_MIN + 5);
		send_measured(m, 0);
		drain();

		// random phases over several limits
		left = N_RANDOM;
		for (int ph = 0; ph < 6 && left > 0; ph++) begin
			case (ph)
				0: random_targets('0);
				1: random_targets(speed_t'(1));
				2: random_targets(speed_t'(2 ** MW - 1));
				3: random_targets(MAX_SPEED_RST);
				default: random_targets(speed_t'($urandom_range(0, 2 ** 17)));
			endcase
			stall_on = (ph != 3);
			for (int k = 0; k < N_RANDOM / 6 && left > 0; k += 8) begin
				if (ph == 1 && k == 40) begin
					hold_off = 300;       // receiver stalls, pipeline fills
					random_burst(100);
					left -= 100;
				end else begin
					random_burst(8);
					left -= 8;
				end
			end
			if (ph == 4) begin
				drain();                 // sender pauses until all results are in
				random_burst(20);
				left -= 20;
			end
			drain();
		end

		$display("Sent %0d measured words, checked %0d commands (%0d speed limited).",
			sent, sb.checked, sb.limited_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d commands outstanding", sb.pending.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
